[sv/mmlc_pkg.sv]
// shared types, constants and helpers for the multi-mode logic combiner
package mmlc_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int FRAC_BITS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int VAL_W     = 32;
  localparam int SUM_W     = VAL_W + CNT_W;

  localparam logic signed [VAL_W-1:0] FX_ONE = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] FX_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] FX_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [4:0] {
    MODE_EQ      = 5'd0,
    MODE_LT      = 5'd1,
    MODE_LE      = 5'd2,
    MODE_GT      = 5'd3,
    MODE_GE      = 5'd4,
    MODE_ANY     = 5'd5,
    MODE_ALL     = 5'd6,
    MODE_NONE    = 5'd7,
    MODE_AVG     = 5'd8,
    MODE_PASS    = 5'd9,
    MODE_TOGGLE  = 5'd10,
    MODE_INVERT  = 5'd11,
    MODE_MAX     = 5'd12,
    MODE_MIN     = 5'd13,
    MODE_MUL     = 5'd14,
    MODE_RUNMAX  = 5'd15,
    MODE_RUNMIN  = 5'd16
  } op_mode_t;

  typedef enum logic [1:0] {
    REG_OP_MODE     = 2'd0,
    REG_INPUTS_USED = 2'd1,
    REG_INPUT_SLOT  = 2'd2,
    REG_REF_SLOT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] prev;
    logic signed [VAL_W-1:0] cur;
  } slot_entry_t;

  // slot number taken modulo the slot count, by repeated subtraction
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [2:0] x);
    logic [5:0] v;
    v = {3'b000, x};
    for (int k = 0; k < 4; k++) begin
      if (v >= 6'(NUM_SLOTS)) begin
        v = v - 6'(NUM_SLOTS);
      end
    end
    return v[SLOT_W-1:0];
  endfunction

  // slot count clamped to 1..NUM_SLOTS
  function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] x);
    logic [CNT_W-1:0] r;
    if (x == 4'd0) begin
      r = CNT_W'(1);
    end else if (32'(x) > NUM_SLOTS) begin
      r = CNT_W'(NUM_SLOTS);
    end else begin
      r = CNT_W'(x);
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > 64'(FX_MAX)) begin
      r = FX_MAX;
    end else if (x < 64'(FX_MIN)) begin
      r = FX_MIN;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/mmlc_slot_mem.sv]
// slot memory: current and previous value per slot, registered read, valid bits for reset
module mmlc_slot_mem
  import mmlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  slot_entry_t       wdata,
  input  logic [SLOT_W-1:0] raddr,
  output slot_entry_t       rdata
);

  slot_entry_t           mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  valid;
  slot_entry_t           rd_q;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // never-written entries read as zero
  assign rdata = rd_valid ? rd_q : '0;

endmodule

[sv/mmlc_div.sv]
// signed sum divided by slot count, restoring, one quotient bit per cycle
module mmlc_div
  import mmlc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic               busy;
  logic [STEP_W-1:0]  steps;
  logic [SUM_W-1:0]   q;
  logic [CNT_W:0]     rem;
  logic [CNT_W-1:0]   d;
  logic               neg;
  logic [CNT_W:0]     rem_sh;
  logic               fits;

  assign rem_sh = {rem[CNT_W-1:0], q[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
        neg   <= dividend[SUM_W-1];
        q     <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        rem   <= '0;
        d     <= divisor;
      end else if (busy) begin
        rem   <= fits ? rem_sh - {1'b0, d} : rem_sh;
        q     <= {q[SUM_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero: sign applied to the magnitude quotient
  assign quotient = neg ? -$signed(q) : $signed(q);

endmodule

[sv/multi_mode_logic_combiner_core.sv]
// top level: slot store, reduction sequencer and output register of the logic combiner
// Each accepted item writes one slot (old value moves to the previous value) and then
// recomputes one result in the configured mode, reading the slot memory one entry per
// step: the item's slot, then the input slot and the reference slot, then slots
// 0..n-1 (n = inputs_used, clamped to 1..8), each slot passing through the memory read,
// the 32x32 multiply and the shift-and-saturate of the product chain. Average mode
// then waits for the bit-serial divider. One item is worked at a time; the result
// sits in an output register so the next item is accepted while it waits. Slot
// values are signed 16.16; outputs of logic modes are 1.0 or 0. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must do so only while no item
// is in flight, as the block does not enforce this.
module multi_mode_logic_combiner_core
  import mmlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [2:0] slot, [34:3] sample, [39:35] zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_OLD, S_INV, S_REF, S_REFD, S_WRD, S_WMUL, S_WSAT, S_EVAL, S_DIV, S_OUT
  } state_t;

  // configuration
  logic [4:0] op_mode;
  logic [3:0] inputs_used;
  logic [2:0] input_slot;
  logic [2:0] reference_slot;

  // sequencer state
  state_t                  state;
  logic [SLOT_W-1:0]       slot_q;
  logic signed [VAL_W-1:0] sample_q;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        n_used;
  logic signed [VAL_W-1:0] inv;
  logic signed [VAL_W-1:0] refv;
  logic signed [VAL_W-1:0] prev0;
  logic signed [VAL_W-1:0] cur0;

  // reduction accumulators
  logic                    any_nz;
  logic                    all_nz;
  logic signed [VAL_W-1:0] max_acc;
  logic signed [VAL_W-1:0] min_acc;
  logic signed [SUM_W-1:0] sum_acc;
  logic signed [VAL_W-1:0] mul_acc;
  logic signed [63:0]      prod;

  // persistent block state
  logic signed [VAL_W-1:0] output_value;
  logic signed [VAL_W-1:0] running_extreme;
  logic                    first_pending;

  // memory port
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_entry_t       mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  slot_entry_t       mem_rdata;

  // divider
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_q;

  logic signed [VAL_W-1:0] d;
  logic [CNT_W-1:0]        idx_inc;
  logic signed [63:0]      prod_sh;
  logic                    run_hit;
  logic signed [VAL_W-1:0] eval_val;

  assign d       = mem_rdata.cur;
  assign idx_inc = idx + CNT_W'(1);
  assign prod_sh = prod >>> FRAC_BITS;
  // no item is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  mmlc_slot_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mmlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (n_used),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory address and write control follow the sequencer state
  always_comb begin
    mem_we    = (state == S_OLD);
    mem_waddr = slot_q;
    mem_wdata = '{prev: mem_rdata.cur, cur: sample_q};
    mem_raddr = idx[SLOT_W-1:0];
    unique case (state)
      S_IDLE:  mem_raddr = wrap_slot(s_tdata[2:0]);
      S_INV:   mem_raddr = wrap_slot(input_slot);
      S_REF:   mem_raddr = wrap_slot(reference_slot);
      default: mem_raddr = idx[SLOT_W-1:0];
    endcase
  end

  assign div_start = (state == S_EVAL) && (op_mode == MODE_AVG);

  // running extreme reload condition
  always_comb begin
    if (op_mode == MODE_RUNMAX) begin
      run_hit = (refv != 0) || first_pending || (inv > running_extreme);
    end else begin
      run_hit = (refv != 0) || first_pending || (inv < running_extreme);
    end
  end

  // new output value for every mode but average
  always_comb begin
    eval_val = output_value;
    unique case (op_mode)
      MODE_EQ:     eval_val = (inv == refv) ? FX_ONE : '0;
      MODE_LT:     eval_val = (inv <  refv) ? FX_ONE : '0;
      MODE_LE:     eval_val = (inv <= refv) ? FX_ONE : '0;
      MODE_GT:     eval_val = (inv >  refv) ? FX_ONE : '0;
      MODE_GE:     eval_val = (inv >= refv) ? FX_ONE : '0;
      MODE_ANY:    eval_val = any_nz ? FX_ONE : '0;
      MODE_ALL:    eval_val = all_nz ? FX_ONE : '0;
      MODE_NONE:   eval_val = any_nz ? '0 : FX_ONE;
      MODE_PASS:   eval_val = cur0;
      MODE_TOGGLE: begin
        if (prev0 < FX_ONE && cur0 >= FX_ONE) begin
          eval_val = (output_value >= FX_ONE) ? '0 : FX_ONE;
        end
      end
      MODE_INVERT: eval_val = (cur0 < FX_ONE) ? FX_ONE : '0;
      MODE_MAX:    eval_val = max_acc;
      MODE_MIN:    eval_val = min_acc;
      MODE_MUL:    eval_val = mul_acc;
      MODE_RUNMAX,
      MODE_RUNMIN: begin
        if (run_hit) begin
          eval_val = inv;
        end
      end
      default:     eval_val = output_value;   // average handled by divider; unused codes hold
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode        <= MODE_PASS;
      inputs_used    <= 4'd2;
      input_slot     <= 3'd0;
      reference_slot <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_MODE:     op_mode        <= cfg_data;
        REG_INPUTS_USED: inputs_used    <= cfg_data[3:0];
        REG_INPUT_SLOT:  input_slot     <= cfg_data[2:0];
        REG_REF_SLOT:    reference_slot <= cfg_data[2:0];
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      output_value    <= '0;
      running_extreme <= '0;
      first_pending   <= 1'b1;
    end else begin
      // a taken result clears the flag unless a new one replaces it
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            slot_q   <= wrap_slot(s_tdata[2:0]);
            sample_q <= s_tdata[34:3];
            n_used   <= clamp_count(inputs_used);
            state    <= S_OLD;
          end
        end
        S_OLD: state <= S_INV;   // write-back of {old current, sample}
        S_INV: state <= S_REF;
        S_REF: begin
          inv   <= d;
          state <= S_REFD;
        end
        S_REFD: begin
          refv    <= d;
          idx     <= '0;
          any_nz  <= 1'b0;
          all_nz  <= 1'b1;
          max_acc <= '0;
          sum_acc <= '0;
          mul_acc <= FX_ONE;
          state   <= S_WRD;
        end
        S_WRD: state <= S_WMUL;
        S_WMUL: begin
          if (idx == '0) begin
            prev0   <= mem_rdata.prev;
            cur0    <= d;
            min_acc <= d;
          end else if (d < min_acc) begin
            min_acc <= d;
          end
          if (d != 0) begin
            any_nz <= 1'b1;
          end else begin
            all_nz <= 1'b0;
          end
          if (d > max_acc) begin
            max_acc <= d;
          end
          sum_acc <= sum_acc + SUM_W'(d);
          prod    <= 64'(mul_acc) * 64'(d);
          state   <= S_WSAT;
        end
        S_WSAT: begin
          mul_acc <= sat_val(prod_sh);
          idx     <= idx_inc;
          state   <= (idx_inc == n_used) ? S_EVAL : S_WRD;
        end
        S_EVAL: begin
          if (op_mode == MODE_AVG) begin
            state <= S_DIV;
          end else begin
            output_value <= eval_val;
            if ((op_mode == MODE_RUNMAX || op_mode == MODE_RUNMIN) && run_hit) begin
              running_extreme <= inv;
              first_pending   <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            output_value <= sat_val(64'(div_q));
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= output_value;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tb.sv]
// testbench for the multi-mode logic combiner: directed table plus random phases, scoreboarded
`timescale 1ns / 100ps

module tb;
  import mmlc_pkg::*;

  // directed table row: either a full register setting or one input item
  typedef struct packed {
    logic        is_cfg;
    logic [4:0]  mode;
    logic [3:0]  used;
    logic [2:0]  in_s;
    logic [2:0]  ref_s;
    logic [2:0]  slot;
    logic [31:0] sample;
    logic        typed;   // expected value typed in the row, else from the predictor
    logic [31:0] want;
  } step_t;

  localparam logic ROW_CFG     = 1'b1;
  localparam logic ROW_ITEM    = 1'b0;
  localparam logic CHECK_TYPED = 1'b1;
  localparam logic CHECK_MODEL = 1'b0;

  // highest code of the spare mode range, output must hold
  localparam logic [4:0] MODE_SPARE_TOP = 5'd31;

  localparam int PHASES          = 24;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int HOLD_PHASE      = 5;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 100;
  localparam int SCRIPT_LEN      = 48;

  localparam logic [31:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_ONE  = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [2:0] slot, [34:3] sample, [39:35] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] result
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_OP_MODE;
  logic [4:0]  cfg_data = '0;

  always #1 clk = ~clk;

  multi_mode_logic_combiner_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor state: slot store, output and running extreme, register copy
  // ---------------------------------------------------------------------------
  logic signed [31:0] slot_now [NUM_SLOTS];
  logic signed [31:0] slot_old [NUM_SLOTS];
  logic signed [31:0] out_q;
  logic signed [31:0] run_ext;
  logic               first_pend;
  logic [4:0]         cfg_mode;
  logic [3:0]         cfg_used;
  logic [2:0]         cfg_in;
  logic [2:0]         cfg_ref;

  logic [31:0] results_due [$];
  int          items_sent;
  int          results_seen;
  int          configs_done;
  int          fails;

  // traffic shaping shared between sender and receiver
  logic tx_burst;
  logic rx_burst;
  logic hold_req;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > longint'(FX_MAX)) return FX_MAX;
    if (x < longint'(FX_MIN)) return FX_MIN;
    return x[31:0];
  endfunction

  // writes one slot and recomputes the output in the current mode
  function automatic logic [31:0] combine(input logic [2:0] slot, input logic [31:0] sample);
    int                 n;
    longint             acc;
    longint             nv;
    logic signed [31:0] a;
    logic signed [31:0] r;
    logic               hit;
    logic               all_set;
    n = (cfg_used == 4'd0) ? 1 : (int'(cfg_used) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_used);
    slot_old[slot] = slot_now[slot];
    slot_now[slot] = sample;
    a = slot_now[cfg_in];
    r = slot_now[cfg_ref];
    nv = out_q;
    hit = 1'b0;
    all_set = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (slot_now[i] != 0) hit = 1'b1;
      else all_set = 1'b0;
    end
    case (cfg_mode)
      MODE_EQ:     nv = (a == r) ? FX_ONE : 0;
      MODE_LT:     nv = (a < r) ? FX_ONE : 0;
      MODE_LE:     nv = (a <= r) ? FX_ONE : 0;
      MODE_GT:     nv = (a > r) ? FX_ONE : 0;
      MODE_GE:     nv = (a >= r) ? FX_ONE : 0;
      MODE_ANY:    nv = hit ? FX_ONE : 0;
      MODE_NONE:   nv = hit ? 0 : FX_ONE;
      MODE_ALL:    nv = all_set ? FX_ONE : 0;
      MODE_AVG: begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += slot_now[i];
        nv = clamp32(acc / n);   // truncates toward zero
      end
      MODE_PASS:   nv = slot_now[0];
      MODE_TOGGLE: begin
        // rising crossing of 1.0 on slot 0 flips the output
        if (slot_old[0] < FX_ONE && slot_now[0] >= FX_ONE) nv = (out_q >= FX_ONE) ? 0 : FX_ONE;
      end
      MODE_INVERT: nv = (slot_now[0] < FX_ONE) ? FX_ONE : 0;
      MODE_MAX: begin
        acc = 0;   // floor of zero
        for (int i = 0; i < n; i++) if (slot_now[i] > acc) acc = slot_now[i];
        nv = acc;
      end
      MODE_MIN: begin
        acc = slot_now[0];
        for (int i = 1; i < n; i++) if (slot_now[i] < acc) acc = slot_now[i];
        nv = acc;
      end
      MODE_MUL: begin
        // fixed-point product chain, floor shift and saturation at every step
        acc = FX_ONE;
        for (int i = 0; i < n; i++) acc = clamp32((acc * slot_now[i]) >>> FRAC_BITS);
        nv = acc;
      end
      MODE_RUNMAX, MODE_RUNMIN: begin
        if (r != 0 || first_pend ||
            (cfg_mode == MODE_RUNMAX ? (a > run_ext) : (a < run_ext))) begin
          run_ext = a;
          nv = a;
          first_pend = 1'b0;
        end
      end
      default: ;   // spare codes keep the output
    endcase
    out_q = clamp32(nv);
    return out_q;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // waits until every result is in, then writes all four registers
  task automatic apply_config(input logic [4:0] mode, input logic [3:0] used,
                              input logic [2:0] in_s, input logic [2:0] ref_s);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    write_reg(REG_OP_MODE, mode);
    write_reg(REG_INPUTS_USED, 5'(used));
    write_reg(REG_INPUT_SLOT, 5'(in_s));
    write_reg(REG_REF_SLOT, 5'(ref_s));
    cfg_we <= 1'b0;
    cfg_mode = mode;
    cfg_used = used;
    cfg_in   = in_s;
    cfg_ref  = ref_s;
    configs_done++;
  endtask

  // offers one item after an idle gap, predicts its result at acceptance
  task automatic feed_item(input logic [2:0] slot, input logic [31:0] sample, input int gap,
                           input logic typed, input logic [31:0] want);
    logic [31:0] model;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, sample, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model = combine(slot, sample);
    results_due.push_back(typed ? want : model);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // directed table, walked in order from reset (pass mode, 2 slots, in 0, ref 1)
  // ---------------------------------------------------------------------------
  step_t script [SCRIPT_LEN] = '{
    // pass mode at both extremes
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, V_MAX, CHECK_TYPED, V_MAX},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, V_MIN, CHECK_TYPED, V_MIN},
    // product of two minimum values saturates high
    '{ROW_CFG, MODE_MUL, 4'd2, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd1, V_MIN, CHECK_TYPED, V_MAX},
    // average of max and min truncates to zero
    '{ROW_CFG, MODE_AVG, 4'd2, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, V_MAX, CHECK_TYPED, 32'h0},
    // slot count zero acts as one
    '{ROW_CFG, MODE_AVG, 4'd0, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd1, V_ONE, CHECK_TYPED, V_MAX},
    // slot count above eight acts as eight
    '{ROW_CFG, MODE_AVG, 4'd15, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, 32'h0003_0000, CHECK_MODEL, '0},
    // exact comparisons
    '{ROW_CFG, MODE_EQ, 4'd8, 3'd1, 3'd2, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, V_ONE, CHECK_TYPED, V_ONE},
    '{ROW_CFG, MODE_LT, 4'd8, 3'd7, 3'd2, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd7, V_MIN, CHECK_TYPED, V_ONE},
    '{ROW_CFG, MODE_LE, 4'd8, 3'd2, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd3, 32'h5, CHECK_TYPED, V_ONE},
    '{ROW_CFG, MODE_GT, 4'd8, 3'd0, 3'd7, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd4, 32'h0, CHECK_TYPED, V_ONE},
    '{ROW_CFG, MODE_GE, 4'd8, 3'd7, 3'd0, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd5, 32'h0000_ffff, CHECK_TYPED, 32'h0},
    // nonzero reductions
    '{ROW_CFG, MODE_ANY, 4'd1, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'h0, CHECK_TYPED, 32'h0},
    '{ROW_CFG, MODE_NONE, 4'd1, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'h0, CHECK_TYPED, V_ONE},
    '{ROW_CFG, MODE_ALL, 4'd8, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'h1, CHECK_TYPED, 32'h0},
    '{ROW_CFG, MODE_ALL, 4'd4, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd3, V_MAX, CHECK_TYPED, V_ONE},
    // invert just below 1.0
    '{ROW_CFG, MODE_INVERT, 4'd4, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'h0000_ffff, CHECK_TYPED, V_ONE},
    // toggle: crossing, no crossing, crossing again
    '{ROW_CFG, MODE_TOGGLE, 4'd4, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, V_ONE, CHECK_TYPED, 32'h0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'hffff_0000, CHECK_TYPED, 32'h0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, V_MAX, CHECK_TYPED, V_ONE},
    // max with its zero floor, min
    '{ROW_CFG, MODE_MAX, 4'd3, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd1, V_MIN, CHECK_TYPED, V_MAX},
    '{ROW_CFG, MODE_MAX, 4'd2, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'hffff_ffff, CHECK_TYPED, 32'h0},
    '{ROW_CFG, MODE_MIN, 4'd2, 3'd0, 3'd1, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, 32'h7, CHECK_TYPED, V_MIN},
    // running max: first load, hold, reload forced by the reference slot
    '{ROW_CFG, MODE_RUNMAX, 4'd2, 3'd2, 3'd6, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, 32'h0005_0000, CHECK_TYPED, 32'h0005_0000},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, 32'h0004_0000, CHECK_TYPED, 32'h0005_0000},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd6, 32'h1, CHECK_TYPED, 32'h0004_0000},
    // running min keeps the extreme left by running max
    '{ROW_CFG, MODE_RUNMIN, 4'd2, 3'd2, 3'd4, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd2, 32'h0003_0000, CHECK_TYPED, 32'h0003_0000},
    // spare mode code holds the output
    '{ROW_CFG, MODE_SPARE_TOP, 4'd2, 3'd2, 3'd4, '0, '0, CHECK_MODEL, '0},
    '{ROW_ITEM, '0, '0, '0, '0, 3'd0, 32'h1234_5678, CHECK_TYPED, 32'h0003_0000}
  };

  // ---------------------------------------------------------------------------
  // stimulus: directed table, then random phases with a fresh setting each
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_t       row;
    logic [4:0]  mode;
    logic [3:0]  used;
    logic [2:0]  slot;
    logic [31:0] sample;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_now[i] = '0;
      slot_old[i] = '0;
    end
    out_q      = '0;
    run_ext    = '0;
    first_pend = 1'b1;
    cfg_mode   = MODE_PASS;
    cfg_used   = 4'd2;
    cfg_in     = 3'd0;
    cfg_ref    = 3'd1;
    tx_burst   = 1'b0;
    rx_burst   = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    configs_done = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      row = script[r];
      if (row.is_cfg) apply_config(row.mode, row.used, row.in_s, row.ref_s);
      else feed_item(row.slot, row.sample, $urandom_range(0, 10), row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // first walk every defined mode once, then random codes including spare ones
      if (p <= int'(MODE_RUNMIN)) mode = 5'(p);
      else if ($urandom_range(0, 3) == 0) mode = 5'($urandom_range(17, 31));
      else mode = 5'($urandom_range(0, 16));
      used = (p % 5 == 0) ? 4'd15 : (p % 5 == 1) ? 4'd1 : 4'($urandom_range(0, 15));
      apply_config(mode, used, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      tx_burst = ($urandom_range(0, 3) == 0) || (p == HOLD_PHASE);
      rx_burst = ($urandom_range(0, 3) == 0);
      // one phase floods the block while the sink holds off
      if (p == HOLD_PHASE) hold_req = 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // favor the slots that the current mode actually looks at
        case ($urandom_range(0, 3))
          0:       slot = cfg_in;
          1:       slot = cfg_ref;
          2:       slot = '0;
          default: slot = 3'($urandom_range(0, 7));
        endcase
        // values near 1.0 and small magnitudes drive crossings and product chains
        case ($urandom_range(0, 9))
          0:       sample = '0;
          1:       sample = FX_ONE;
          2:       sample = FX_ONE + 32'($urandom_range(0, 2)) - 32'd1;
          3, 4, 5: sample = 32'($urandom_range(0, 8 * FX_ONE)) - 32'(4 * FX_ONE);
          6:       sample = $urandom_range(0, 1) ? FX_MAX : FX_MIN;
          default: sample = $urandom;
        endcase
        // running modes mostly see a quiet reference slot so the extreme can build up
        if ((cfg_mode == MODE_RUNMAX || cfg_mode == MODE_RUNMIN) && slot == cfg_ref &&
            $urandom_range(0, 4) != 0) sample = '0;
        feed_item(slot, sample, tx_burst ? 0 : $urandom_range(0, 10), CHECK_MODEL, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items across %0d register settings, every mode and spare codes",
             items_sent, configs_done);
    $display("run: %0d results compared, %0d failures", results_seen, fails);
    if (fails == 0) begin
      $display("multi_mode_logic_combiner_core test passed");
    end else begin
      $display("multi_mode_logic_combiner_core test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls per item, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  initial results_seen = 0;
  initial fails = 0;

  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("result: no item pending, got %h", m_tdata);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (m_tdata !== want) begin
          $error("result: expected %h, got %h", want, m_tdata);
          fails++;
        end
        results_seen++;
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("multi_mode_logic_combiner_core test failed");
    $finish;
  end

endmodule

[filelist.f]
sv/mmlc_pkg.sv
sv/mmlc_slot_mem.sv
sv/mmlc_div.sv
sv/multi_mode_logic_combiner_core.sv
sim/tb.sv
